FILE: src/uer_pkg.sv
// Types and constants shared by the ultrasonic echo ranger.
package uer_pkg;

  localparam int TICK_W  = 20;  // holds a full pause of 1000 ms in us ticks
  localparam int PULSE_W = 16;
  localparam int CFG_W   = 10;
  localparam int DIST_W  = 11;
  localparam int US_W    = 17;

  localparam logic [CFG_W-1:0]   PERIOD_MIN_MS      = 10'd50;
  localparam logic [CFG_W-1:0]   PERIOD_MAX_MS      = 10'd1000;
  localparam logic [TICK_W-1:0]  US_PER_MS          = 20'd1000;
  localparam logic [TICK_W-1:0]  PERIOD_RESET_TICKS = 20'd100000;

  // floor(p*16/931) == (p * DIV_MAGIC) >> DIV_SHIFT, exact for any 16-bit p
  localparam int                 MAGIC_W   = 21;
  localparam int                 PROD_W    = PULSE_W + MAGIC_W;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 21'd1153321;
  localparam int                 DIV_SHIFT = 26;

  localparam logic [DIST_W-1:0]  DIST_MAX  = 11'd1023;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 16'hFFFF;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_PRE_LOW   = 5'b00010,
    PH_TRIG_HIGH = 5'b00100,
    PH_LISTEN    = 5'b01000,
    PH_PAUSE     = 5'b10000
  } phase_t;

endpackage

FILE: src/ultrasonic_echo_ranger.sv
// Ultrasonic ranging sequencer: one input item per microsecond tick, one result item per tick.
// Each input item is one microsecond tick carrying the sampled echo pin and a run flag; each
// produces exactly one result item with the trigger pin level and, on report ticks, the echo
// pulse width in us and the distance in cm (pulse*16/931, saturated at 1023), or -1 for both on
// timeout. While run is high the block drives the trigger low for PRE_LOW_US ticks, high for
// TRIGGER_HIGH_US ticks, listens for two echo edges for up to TIMEOUT_US ticks, reports, then
// pauses cycle_period_ms*1000 ticks. Run low idles it at once. The block takes one item every
// cycle while the output is not stalled; each result is registered (the item sits in the input
// register, and the sequencer step and the constant-reciprocal multiply write the result
// register when the pipe advances). cfg_data is taken when cfg_we is high; values outside
// 50..1000 are dropped. Write it only while idle.
module ultrasonic_echo_ranger #(
  parameter int TIMEOUT_US      = 50000,
  parameter int TRIGGER_HIGH_US = 10,
  parameter int PRE_LOW_US      = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          echo_level,
  input  logic                          run,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          trigger_level,
  output logic                          report_valid,
  output logic signed [uer_pkg::DIST_W-1:0] distance_cm,
  output logic signed [uer_pkg::US_W-1:0]   pulse_us
);
  import uer_pkg::*;

  // input register
  logic in_q_valid;
  logic in_echo;
  logic in_run;

  // sequencer state
  phase_t              phase, phase_next;
  logic [TICK_W-1:0]   tick_counter, tick_next;
  logic                echo_previous, echo_prev_next;
  logic [1:0]          edges_seen, edges_next;
  logic [PULSE_W-1:0]  pulse_counter, pulse_next;
  logic [TICK_W-1:0]   period_ticks;

  // step results
  logic                res_trig;
  logic                res_report;
  logic [DIST_W-1:0]   res_dist;
  logic [US_W-1:0]     res_pulse;

  logic                advance;
  logic                load;
  phase_t              cur_phase;
  logic [TICK_W-1:0]   tick_inc;
  logic [PULSE_W-1:0]  pulse_inc;
  logic [PROD_W-1:0]   prod;
  logic [DIST_W-1:0]   quot;
  logic                edge_hit;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !advance;
  assign load     = in_q_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall) begin
      in_echo <= echo_level;
      in_run  <= run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks <= PERIOD_RESET_TICKS;
    end else if (cfg_we && cfg_data >= PERIOD_MIN_MS && cfg_data <= PERIOD_MAX_MS) begin
      period_ticks <= TICK_W'(cfg_data * US_PER_MS);
    end
  end

  // idle steps straight into the first pre-low tick
  assign cur_phase = (phase == PH_IDLE) ? PH_PRE_LOW : phase;
  assign tick_inc  = (phase == PH_IDLE) ? TICK_W'(1) : tick_counter + TICK_W'(1);
  assign pulse_inc = (edges_seen == 2'd1 && pulse_counter != PULSE_MAX)
                     ? pulse_counter + PULSE_W'(1) : pulse_counter;
  assign edge_hit  = in_echo != echo_previous;
  assign prod      = PROD_W'(pulse_inc) * PROD_W'(DIV_MAGIC);
  assign quot      = prod[DIV_SHIFT +: DIST_W];

  always_comb begin
    phase_next     = phase;
    tick_next      = tick_counter;
    echo_prev_next = echo_previous;
    edges_next     = edges_seen;
    pulse_next     = pulse_counter;
    res_trig       = 1'b0;
    res_report     = 1'b0;
    res_dist       = '0;
    res_pulse      = '0;
    if (!in_run) begin
      phase_next     = PH_IDLE;
      tick_next      = '0;
      echo_prev_next = 1'b0;
      edges_next     = '0;
      pulse_next     = '0;
    end else begin
      unique case (cur_phase)
        PH_PRE_LOW: begin
          phase_next = PH_PRE_LOW;
          tick_next  = tick_inc;
          if (tick_inc >= TICK_W'(PRE_LOW_US)) begin
            phase_next = PH_TRIG_HIGH;
            tick_next  = '0;
          end
        end
        PH_TRIG_HIGH: begin
          res_trig  = 1'b1;
          tick_next = tick_inc;
          if (tick_inc >= TICK_W'(TRIGGER_HIGH_US)) begin
            phase_next     = PH_LISTEN;
            tick_next      = '0;
            edges_next     = '0;
            pulse_next     = '0;
            echo_prev_next = in_echo;
          end
        end
        PH_LISTEN: begin
          echo_prev_next = in_echo;
          tick_next      = tick_inc;
          pulse_next     = pulse_inc;
          if (edge_hit && edges_seen == 2'd0) begin
            edges_next = 2'd1;
            pulse_next = '0;
          end
          if (edge_hit && edges_seen != 2'd0) begin
            // the closing edge wins over a timeout that arrives together with it
            edges_next = 2'd2;
            res_report = 1'b1;
            res_pulse  = US_W'(pulse_inc);
            res_dist   = (quot > DIST_MAX) ? DIST_MAX : quot;
            phase_next = PH_PAUSE;
            tick_next  = '0;
          end else if (tick_inc >= TICK_W'(TIMEOUT_US)) begin
            res_report = 1'b1;
            res_pulse  = '1;
            res_dist   = '1;
            phase_next = PH_PAUSE;
            tick_next  = '0;
          end
        end
        PH_PAUSE: begin
          tick_next = tick_inc;
          if (tick_inc >= period_ticks) begin
            phase_next = PH_PRE_LOW;
            tick_next  = '0;
          end
        end
        default: begin
          phase_next     = PH_IDLE;
          tick_next      = '0;
          echo_prev_next = 1'b0;
          edges_next     = '0;
          pulse_next     = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_counter  <= '0;
      echo_previous <= 1'b0;
      edges_seen    <= '0;
      pulse_counter <= '0;
    end else if (load) begin
      phase         <= phase_next;
      tick_counter  <= tick_next;
      echo_previous <= echo_prev_next;
      edges_seen    <= edges_next;
      pulse_counter <= pulse_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_q_valid;
    end
    if (load) begin
      trigger_level <= res_trig;
      report_valid  <= res_report;
      distance_cm   <= res_dist;
      pulse_us      <= res_pulse;
    end
  end

  a_report_to_pause: assert property (@(posedge clk) disable iff (rst)
    load && res_report |=> phase == PH_PAUSE)
    else $error("report did not move sequencer to pause");

  a_stop_idles: assert property (@(posedge clk) disable iff (rst)
    load && !in_run |=> phase == PH_IDLE && tick_counter == '0)
    else $error("run low did not idle sequencer");

  a_timeout_both: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_valid && pulse_us == '1 |-> distance_cm == '1)
    else $error("timeout reported with a real distance");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !report_valid |-> distance_cm == '0 && pulse_us == '0)
    else $error("nonzero fields without report");

  a_trig_no_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && trigger_level |-> !report_valid)
    else $error("report during trigger pulse");

endmodule
